// ===== rtl/csp_pkg.sv =====
`timescale 1ns / 1ps
package csp_pkg;

	localparam int unsigned DirW   = 32;
	localparam int unsigned CfgW   = 31;
	localparam int unsigned SumW   = 64;
	localparam int unsigned NumW   = 63;
	localparam int unsigned QuotW  = 31;
	localparam int unsigned SqrtSteps = SumW / 2;
	localparam int unsigned IdxW   = 8;

	localparam logic [IdxW-1:0] RegRadius     = IdxW'(0);
	localparam logic [IdxW-1:0] RegHalfHeight = IdxW'(1);

	localparam logic [CfgW-1:0] RadiusReset     = CfgW'(65536);
	localparam logic [CfgW-1:0] HalfHeightReset = CfgW'(65536);

	// square root lane state
	typedef struct packed {
		logic [SumW-1:0] x;
		logic [SumW-1:0] res;
		logic [NumW-1:0] num_x;
		logic [NumW-1:0] num_y;
		logic            neg_x;
		logic            neg_y;
		logic [DirW-1:0] pz;
	} sq_t;

	// divider lane state
	typedef struct packed {
		logic [NumW-1:0]  rem_x;
		logic [NumW-1:0]  rem_y;
		logic [QuotW-1:0] q_x;
		logic [QuotW-1:0] q_y;
		logic [DirW-1:0]  div;
		logic             nz;
		logic             neg_x;
		logic             neg_y;
		logic [DirW-1:0]  pz;
	} dv_t;

endpackage

// ===== rtl/csp_dir_if.sv =====
`timescale 1ns / 1ps
interface csp_dir_if import csp_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [DirW-1:0] dir_x;
	logic [DirW-1:0] dir_y;
	logic [DirW-1:0] dir_z;
	modport source (output valid, dir_x, dir_y, dir_z, input ready);
	modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

// ===== rtl/csp_point_if.sv =====
`timescale 1ns / 1ps
interface csp_point_if import csp_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [DirW-1:0] point_x;
	logic [DirW-1:0] point_y;
	logic [DirW-1:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== rtl/csp_cfg_if.sv =====
`timescale 1ns / 1ps
interface csp_cfg_if import csp_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IdxW-1:0] index;
	logic [DirW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/csp_sqrt_step.sv =====
`timescale 1ns / 1ps
module csp_sqrt_step import csp_pkg::*; #(
	parameter int unsigned K = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  sq_t  d_in,
	output logic v_out,
	output sq_t  d_out
);
	localparam logic [SumW-1:0] Bit = SumW'(1) << (SumW - 2 - 2 * K);

	sq_t             nxt;
	logic [SumW-1:0] trial;

	always_comb begin
		nxt   = d_in;
		trial = d_in.res + Bit;
		if (d_in.x >= trial) begin
			nxt.x   = d_in.x - trial;
			nxt.res = (d_in.res >> 1) + Bit;
		end else begin
			nxt.res = d_in.res >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

// ===== rtl/csp_div_step.sv =====
`timescale 1ns / 1ps
module csp_div_step import csp_pkg::*; #(
	parameter int unsigned I = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  dv_t  d_in,
	output logic v_out,
	output dv_t  d_out
);
	dv_t             nxt;
	logic [NumW-1:0] shifted;

	always_comb begin
		nxt     = d_in;
		shifted = NumW'(d_in.div) << I;
		if (d_in.rem_x >= shifted) begin
			nxt.rem_x  = d_in.rem_x - shifted;
			nxt.q_x[I] = 1'b1;
		end
		if (d_in.rem_y >= shifted) begin
			nxt.rem_y  = d_in.rem_y - shifted;
			nxt.q_y[I] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= nxt;
		end
	end
endmodule

// ===== rtl/cylinder_support_point.sv =====
`timescale 1ns / 1ps
// Support point of a z-aligned cylinder, Q16.16. One item enters per cycle
// and a result leaves per cycle while no stall holds the pipeline. An
// accepted input loads the first of 67 registers, which are three front
// stages (magnitudes, squares, square sum with the radius products), 32
// stages of the bit-pair square root (one result bit each), 31 stages of
// restoring division (one quotient bit each, x and y in parallel) and the
// output register. A two-entry output buffer lets the pipeline keep running
// into a stall until the spare entry fills; the pipeline holds while the
// spare entry is full. Configuration writes are always ready and must only
// happen while no item is in flight.
module cylinder_support_point import csp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	csp_dir_if.sink       dir,
	csp_point_if.source   point,
	csp_cfg_if.sink       cfg
);
	logic [CfgW-1:0] radius_q, half_height_q;
	logic            en;

	// configuration
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= RadiusReset;
			half_height_q <= HalfHeightReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				RegRadius:     radius_q      <= cfg.data[CfgW-1:0];
				RegHalfHeight: half_height_q <= cfg.data[CfgW-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: magnitudes, signs, z result
	logic            v_s1, neg_x_s1, neg_y_s1;
	logic [DirW-1:0] ax_s1, ay_s1, pz_s1;
	logic            nx, ny;
	logic [DirW-1:0] hh_ext;

	assign nx     = dir.dir_x[DirW-1];
	assign ny     = dir.dir_y[DirW-1];
	assign hh_ext = {1'b0, half_height_q};
	assign dir.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= dir.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			neg_x_s1 <= nx;
			neg_y_s1 <= ny;
			ax_s1    <= nx ? (~dir.dir_x + DirW'(1)) : dir.dir_x;
			ay_s1    <= ny ? (~dir.dir_y + DirW'(1)) : dir.dir_y;
			// only a strictly positive z picks the top face
			pz_s1    <= ($signed(dir.dir_z) > 0) ? hh_ext : (~hh_ext + DirW'(1));
		end
	end

	// stage 2: squares
	logic            v_s2, neg_x_s2, neg_y_s2;
	logic [DirW-1:0] ax_s2, ay_s2, pz_s2;
	logic [SumW-1:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2   <= SumW'(ax_s1) * SumW'(ax_s1);
			sqy_s2   <= SumW'(ay_s1) * SumW'(ay_s1);
			ax_s2    <= ax_s1;
			ay_s2    <= ay_s1;
			neg_x_s2 <= neg_x_s1;
			neg_y_s2 <= neg_y_s1;
			pz_s2    <= pz_s1;
		end
	end

	// stage 3: square sum and radius products
	logic v_s3;
	sq_t  sq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3.x     <= sqx_s2 + sqy_s2;
			sq_s3.res   <= '0;
			sq_s3.num_x <= NumW'(radius_q) * NumW'(ax_s2);
			sq_s3.num_y <= NumW'(radius_q) * NumW'(ay_s2);
			sq_s3.neg_x <= neg_x_s2;
			sq_s3.neg_y <= neg_y_s2;
			sq_s3.pz    <= pz_s2;
		end
	end

	// square root chain
	logic sq_v [SqrtSteps+1];
	sq_t  sq_d [SqrtSteps+1];
	assign sq_v[0] = v_s3;
	assign sq_d[0] = sq_s3;

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
		csp_sqrt_step #(.K(k)) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (sq_v[k]),
			.d_in  (sq_d[k]),
			.v_out (sq_v[k+1]),
			.d_out (sq_d[k+1])
		);
	end

	// hand over to the divider: the norm is the divisor
	dv_t dv_start;
	always_comb begin
		dv_start.rem_x = sq_d[SqrtSteps].num_x;
		dv_start.rem_y = sq_d[SqrtSteps].num_y;
		dv_start.q_x   = '0;
		dv_start.q_y   = '0;
		dv_start.div   = sq_d[SqrtSteps].res[DirW-1:0];
		dv_start.nz    = (sq_d[SqrtSteps].res == '0);
		dv_start.neg_x = sq_d[SqrtSteps].neg_x;
		dv_start.neg_y = sq_d[SqrtSteps].neg_y;
		dv_start.pz    = sq_d[SqrtSteps].pz;
	end

	// division chain, quotient MSB first
	logic dv_v [QuotW+1];
	dv_t  dv_d [QuotW+1];
	assign dv_v[0] = sq_v[SqrtSteps];
	assign dv_d[0] = dv_start;

	for (genvar j = 0; j < QuotW; j++) begin : g_div
		csp_div_step #(.I(QuotW - 1 - j)) u_step (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_in  (dv_v[j]),
			.d_in  (dv_d[j]),
			.v_out (dv_v[j+1]),
			.d_out (dv_d[j+1])
		);
	end

	// result forming: drop the quotient on a zero norm, restore signs
	logic [DirW-1:0] qx, qy, res_x, res_y, res_z;
	logic            last_v;
	assign last_v = dv_v[QuotW];
	assign qx     = dv_d[QuotW].nz ? '0 : {1'b0, dv_d[QuotW].q_x};
	assign qy     = dv_d[QuotW].nz ? '0 : {1'b0, dv_d[QuotW].q_y};
	assign res_x  = dv_d[QuotW].neg_x ? (~qx + DirW'(1)) : qx;
	assign res_y  = dv_d[QuotW].neg_y ? (~qy + DirW'(1)) : qy;
	assign res_z  = dv_d[QuotW].pz;

	// output register plus spare entry
	logic            out_v_q, skid_v_q;
	logic [DirW-1:0] out_x_q, out_y_q, out_z_q;
	logic [DirW-1:0] skid_x_q, skid_y_q, skid_z_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (point.ready) skid_v_q <= 1'b0;
		end else if (last_v) begin
			if (!out_v_q || point.ready) out_v_q  <= 1'b1;
			else                         skid_v_q <= 1'b1;
		end else if (point.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (point.ready) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_z_q <= skid_z_q;
			end
		end else if (last_v) begin
			if (!out_v_q || point.ready) begin
				out_x_q <= res_x;
				out_y_q <= res_y;
				out_z_q <= res_z;
			end else begin
				skid_x_q <= res_x;
				skid_y_q <= res_y;
				skid_z_q <= res_z;
			end
		end
	end

	assign point.valid   = out_v_q;
	assign point.point_x = out_x_q;
	assign point.point_y = out_y_q;
	assign point.point_z = out_z_q;

	// the spare entry is only ever used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("spare entry full with empty output register");

	// a full spare entry holds the pipeline
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> (last_v == $past(last_v)))
		else $error("pipeline moved while output buffer full");

	// z result is plus or minus the half height
	a_pz_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !cfg.valid) |-> (out_z_q == hh_ext || out_z_q == (~hh_ext + DirW'(1))))
		else $error("point_z magnitude differs from half height");
endmodule
